/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the bag table sequencer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is low
`define MBT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define MBT_NEVER(label, cond, msg) \
    `MBT_ASSERT(label, !(cond), msg)

`endif

/* sv/mbt_pkg.sv */
// ----------------------------------------------------------------------------
// mbt_pkg
// shared constants, codes and types of the bag table
// ----------------------------------------------------------------------------
`default_nettype none

package mbt_pkg;

    localparam int BAG_DEPTH = 16;
    localparam int ITEM_BITS = 32;

    // stored item width: the value field is 32 bits wide
    localparam int ITEM_W = (ITEM_BITS < 32) ? ITEM_BITS : 32;
    localparam int IDX_W  = (BAG_DEPTH > 1) ? $clog2(BAG_DEPTH) : 1;
    localparam int CNT_W  = $clog2(BAG_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;

    localparam logic [4:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    // control that the sequencer drives into every cell
    typedef struct packed {
        logic              shift;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [ITEM_W-1:0] wr_data;
    } cell_ctl_t;

endpackage

`default_nettype wire

/* sv/mbt_ifs.sv */
// ----------------------------------------------------------------------------
// mbt_ifs
// valid/ready channels of the bag table: request, response, capacity write
// ----------------------------------------------------------------------------
`default_nettype none

interface mbt_req_if
    import mbt_pkg::*;
;
    logic        valid;
    logic        ready;
    op_t         operation;
    logic [31:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface mbt_rsp_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [4:0] copies_held;
    logic       present;
    logic [4:0] entries_held;

    modport source (output valid, output ok, output copies_held, output present,
                    output entries_held, input ready);
    modport sink   (input valid, input ok, input copies_held, input present,
                    input entries_held, output ready);
endinterface

interface mbt_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] capacity_in_use;

    modport source (output valid, output capacity_in_use, input ready);
    modport sink   (input valid, input capacity_in_use, output ready);
endinterface

`default_nettype wire

/* sv/mbt_cell.sv */
// ----------------------------------------------------------------------------
// mbt_cell
// one storage cell of the rotating entry ring
// ----------------------------------------------------------------------------
`default_nettype none

module mbt_cell
    import mbt_pkg::*;
(
    input  wire logic              clk,
    input  wire cell_ctl_t         ctl,
    input  wire logic [IDX_W-1:0]  cell_idx,
    input  wire logic [ITEM_W-1:0] shift_in,
    output logic      [ITEM_W-1:0] q
);

    logic [ITEM_W-1:0] entry_reg;
    logic [ITEM_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift)
        begin
            entry_next = shift_in;
        end
        else if (ctl.wr_en && (ctl.wr_idx == cell_idx))
        begin
            entry_next = ctl.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

`default_nettype wire

/* sv/mbt_ctrl.sv */
// ----------------------------------------------------------------------------
// mbt_ctrl
// sequencer: walks the ring past one comparator, then updates and reports
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mbt_ctrl
    import mbt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    mbt_req_if.sink                req,
    mbt_rsp_if.source              rsp,
    mbt_cfg_if.sink                cfg,
    input  wire logic [ITEM_W-1:0] head,
    output cell_ctl_t              cell_ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_UPD
    } state_t;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [ITEM_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]  match_reg, match_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  fidx_reg, fidx_next;
    logic [ITEM_W-1:0] last_reg, last_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [4:0]        cap_reg, cap_next;
    logic              ovalid_reg, ovalid_next;
    logic              ok_reg, ok_next;
    logic [4:0]        copies_reg, copies_next;
    logic              present_reg, present_next;
    logic [4:0]        entries_reg, entries_next;

    logic              slot_live;
    logic              hit;
    logic              out_free;
    logic              room;
    logic [CMP_W-1:0]  cap_eff;
    logic [CNT_W-1:0]  copies_new;
    logic [CNT_W-1:0]  count_new;
    logic              ok_new;
    logic              walk_mid;
    logic              rm_commit;

    assign slot_live = CNT_W'(step_reg) < count_reg;
    assign hit       = slot_live && (head == val_reg);
    assign out_free  = !ovalid_reg || rsp.ready;
    assign cap_eff   = (CMP_W'(cap_reg) > CMP_W'(BAG_DEPTH)) ? CMP_W'(BAG_DEPTH)
                                                            : CMP_W'(cap_reg);
    assign room      = CMP_W'(count_reg) < cap_eff;
    assign walk_mid  = (state_reg == S_WALK) && (step_reg != IDX_W'(BAG_DEPTH - 1));
    assign rm_commit = (state_reg == S_UPD) && out_free && (op_reg == OP_REMOVE)
                       && found_reg;

    // result and store update of the finishing item
    always_comb
    begin
        ok_new           = 1'b1;
        copies_new       = match_reg;
        count_new        = count_reg;
        cell_ctl.shift   = (state_reg == S_WALK);
        cell_ctl.wr_en   = 1'b0;
        cell_ctl.wr_idx  = count_reg[IDX_W-1:0];
        cell_ctl.wr_data = val_reg;
        case (op_reg)
            OP_ADD:
            begin
                ok_new = room;
                if (room)
                begin
                    copies_new     = match_reg + 1'b1;
                    count_new      = count_reg + 1'b1;
                    cell_ctl.wr_en = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                ok_new = found_reg;
                if (found_reg)
                begin
                    // last entry fills the hole
                    copies_new       = match_reg - 1'b1;
                    count_new        = count_reg - 1'b1;
                    cell_ctl.wr_en   = 1'b1;
                    cell_ctl.wr_idx  = fidx_reg;
                    cell_ctl.wr_data = last_reg;
                end
            end
            OP_CLEAR:
            begin
                copies_new = '0;
                count_new  = '0;
            end
            default:
            begin
                copies_new = match_reg;
            end
        endcase
        if (!((state_reg == S_UPD) && out_free))
        begin
            cell_ctl.wr_en = 1'b0;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        step_next    = step_reg;
        match_next   = match_reg;
        found_next   = found_reg;
        fidx_next    = fidx_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        cap_next     = cap_reg;
        ovalid_next  = ovalid_reg && !rsp.ready;
        ok_next      = ok_reg;
        copies_next  = copies_reg;
        present_next = present_reg;
        entries_next = entries_reg;

        if (cfg.valid)
        begin
            cap_next = cfg.capacity_in_use;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.operation;
                    val_next   = req.value[ITEM_W-1:0];
                    step_next  = '0;
                    match_next = '0;
                    found_next = 1'b0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (hit)
                begin
                    match_next = match_reg + 1'b1;
                    if (!found_reg)
                    begin
                        found_next = 1'b1;
                        fidx_next  = step_reg;
                    end
                end
                if ((CNT_W'(step_reg) + 1'b1) == count_reg)
                begin
                    last_next = head;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == IDX_W'(BAG_DEPTH - 1))
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    count_next   = count_new;
                    ovalid_next  = 1'b1;
                    ok_next      = ok_new;
                    copies_next  = 5'(copies_new);
                    present_next = (copies_new != '0);
                    entries_next = 5'(count_new);
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cap_reg    <= CAP_RESET;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cap_reg    <= cap_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        val_reg     <= val_next;
        step_reg    <= step_next;
        match_reg   <= match_next;
        found_reg   <= found_next;
        fidx_reg    <= fidx_next;
        last_reg    <= last_next;
        ok_reg      <= ok_next;
        copies_reg  <= copies_next;
        present_reg <= present_next;
        entries_reg <= entries_next;
    end

    // no beat is taken while reset is held
    assign req.ready        = rst_n && (state_reg == S_IDLE);
    assign cfg.ready        = rst_n;
    assign rsp.valid        = ovalid_reg;
    assign rsp.ok           = ok_reg;
    assign rsp.copies_held  = copies_reg;
    assign rsp.present      = present_reg;
    assign rsp.entries_held = entries_reg;

    `MBT_NEVER(a_count_range, count_reg > CNT_W'(BAG_DEPTH), "entry count above depth")
    `MBT_ASSERT(a_walk_step, walk_mid |=> (step_reg == $past(step_reg) + 1'b1), "walk step skipped")
    `MBT_ASSERT(a_rsp_src, $rose(ovalid_reg) |-> ($past(state_reg) == S_UPD), "stray result")
    `MBT_ASSERT(a_rm_shrink, rm_commit |=> (count_reg == $past(count_reg) - 1'b1), "remove kept count")

endmodule

`default_nettype wire

/* sv/multiset_bag_table.sv */
// ----------------------------------------------------------------------------
// multiset_bag_table
// fixed-capacity bag of values: add, remove, clear and query per beat
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | beat
//  req     | in  | operation, value                         | one request
//  rsp     | out | ok, copies_held, present, entries_held   | one result per request
//  cfg     | in  | capacity_in_use                          | one capacity write
//
// - entries sit in a ring of BAG_DEPTH cells that rotates one place a cycle
//   past a single comparator at the head cell while a request is walked
// - a request goes from accept to the next accept through an idle/accept
//   state, a walk state over all BAG_DEPTH cells and an update state
// - the update cycle waits while the previous result is still unclaimed
// - reset empties the bag and sets the capacity to 16; cell contents are
//   left as they are, only entries below the count are ever looked at
// - outside reset, capacity writes are taken every cycle
// ----------------------------------------------------------------------------
`default_nettype none

module multiset_bag_table
    import mbt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    mbt_req_if.sink   req,
    mbt_rsp_if.source rsp,
    mbt_cfg_if.sink   cfg
);

    // cell outputs, cell 0 is the head seen by the comparator
    logic [ITEM_W-1:0] cell_q [BAG_DEPTH];
    cell_ctl_t         cell_ctl;

    mbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cfg      (cfg),
        .head     (cell_q[0]),
        .cell_ctl (cell_ctl)
    );

    // ring: each cell takes its upper neighbor, the top cell wraps to the head
    for (genvar j = 0; j < BAG_DEPTH; j++)
    begin : g_cell
        localparam int NXT = (j + 1) % BAG_DEPTH;

        mbt_cell u_cell (
            .clk      (clk),
            .ctl      (cell_ctl),
            .cell_idx (IDX_W'(j)),
            .shift_in (cell_q[NXT]),
            .q        (cell_q[j])
        );
    end

endmodule

`default_nettype wire

/* dv/tb_multiset_bag_table.sv */
// ----------------------------------------------------------------------------
// tb_multiset_bag_table
// self-checking bench for the bag table: add, remove, clear and query beats
// ----------------------------------------------------------------------------
// a request queue feeds a clocked driver and a clocked monitor checks every
// response beat against a shadow copy of the bag kept by the bench. The run
// opens with a directed pass over the corner cases, then goes through random
// phases at several capacity settings with different amounts of source
// idling and sink stalling. One phase also holds the response sink off for a
// long stretch so that the table backs up into the request channel.
// ----------------------------------------------------------------------------

module tb_multiset_bag_table;

    import mbt_pkg::*;

    // drain pause after the last result: one full walk plus slack
    localparam int DRAIN_CYCLES = BAG_DEPTH + 24;
    // long sink hold-off used once to back the table up
    localparam int HOLD_CYCLES  = 400;
    localparam int NUM_PHASES   = 7;

    // one request beat
    typedef struct packed {
        op_t         op;
        logic [31:0] value;
    } bag_req_t;

    // one response beat as the shadow bag predicts it
    typedef struct packed {
        logic       ok;
        logic [4:0] copies;
        logic       present;
        logic [4:0] entries;
    } bag_result_t;

    logic clk = 1'b0;
    logic rst_n;

    mbt_req_if req_ch ();
    mbt_rsp_if rsp_ch ();
    mbt_cfg_if cfg_ch ();

    multiset_bag_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always #5 clk = ~clk;

    // request beats waiting for the driver, results waiting for the dut
    bag_req_t    pending_reqs[$];
    bag_result_t awaited_results[$];

    // shadow bag: entries below shadow_fill are live
    logic [ITEM_W-1:0] shadow_vals[BAG_DEPTH];
    int unsigned       shadow_fill = 0;
    logic [4:0]        shadow_cap  = CAP_RESET;

    // traffic shaping, set per phase by the stimulus block
    int unsigned send_idle_pct = 0;
    int unsigned rsp_stall_pct = 0;
    bit          hold_arm      = 1'b0;

    // sink hold-off bookkeeping, owned by the ready driver
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;

    // bookkeeping
    bit          req_taken     = 1'b0;
    int unsigned reqs_queued   = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned refused_ops   = 0;
    int unsigned peak_fill     = 0;
    int unsigned peak_copies   = 0;
    int unsigned cap_writes    = 0;

    // per-phase plan of the random part
    int unsigned phase_cap[NUM_PHASES]   = '{31, 16, 5, 16, 16, 3, 16};
    int unsigned phase_items[NUM_PHASES] = '{300, 250, 200, 250, 150, 150, 200};
    int unsigned phase_idle[NUM_PHASES]  = '{0, 67, 0, 6, 0, 67, 0};
    int unsigned phase_stall[NUM_PHASES] = '{0, 0, 67, 6, 0, 67, 0};
    int          pressure_phase          = 4;

    // apply one operation to the shadow bag and return what the dut should say
    function automatic bag_result_t apply_bag_op(op_t op, logic [31:0] val);
        bag_result_t       res;
        int unsigned       limit;
        int                hit;
        int unsigned       n;
        logic [ITEM_W-1:0] key;
        key   = val[ITEM_W-1:0];
        // capacity above the depth acts as the depth
        limit = (shadow_cap > BAG_DEPTH) ? BAG_DEPTH : shadow_cap;
        res.ok = 1'b1;
        case (op)
            OP_ADD:
            begin
                // capacity below the fill just refuses adds, nothing is dropped
                if (shadow_fill < limit)
                begin
                    shadow_vals[shadow_fill] = key;
                    shadow_fill++;
                end
                else
                    res.ok = 1'b0;
            end
            OP_REMOVE:
            begin
                hit = -1;
                for (int i = 0; i < shadow_fill; i++)
                    if (hit < 0 && shadow_vals[i] == key)
                        hit = i;
                // first match is overwritten by the last live entry
                if (hit >= 0)
                begin
                    shadow_fill--;
                    shadow_vals[hit] = shadow_vals[shadow_fill];
                end
                else
                    res.ok = 1'b0;
            end
            OP_CLEAR:
                shadow_fill = 0;
            default:
                ;
        endcase
        n = 0;
        for (int i = 0; i < shadow_fill; i++)
            if (shadow_vals[i] == key)
                n++;
        res.copies  = 5'(n);
        res.present = (n != 0);
        res.entries = 5'(shadow_fill);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // request driver: holds a beat until taken, idles at random
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        bag_req_t nxt;
        if (rst_n && (!req_ch.valid || req_taken))
        begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_reqs.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.operation <= nxt.op;
                req_ch.value     <= nxt.value;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // response ready driver: random stalls plus a one-time long hold-off
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_arm && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // ------------------------------------------------------------------
    // monitor: capacity writes and accepted requests feed the shadow bag,
    // every response beat is checked against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bag_result_t want;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                shadow_cap = cfg_ch.capacity_in_use;
                cap_writes++;
            end

            if (req_ch.valid && req_ch.ready)
            begin
                want = apply_bag_op(req_ch.operation, req_ch.value);
                awaited_results = {awaited_results, want};
                if (!want.ok)
                    refused_ops++;
                if (want.entries > peak_fill)
                    peak_fill = want.entries;
                if (want.copies > peak_copies)
                    peak_copies = want.copies;
            end
            req_taken = req_ch.valid && req_ch.ready;

            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (awaited_results.size() == 0)
                begin
                    $error("response beat with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_ch.ok !== want.ok)
                    begin
                        $error("ok: expected %0d, got %0d", want.ok, rsp_ch.ok);
                        mismatches++;
                    end
                    if (rsp_ch.copies_held !== want.copies)
                    begin
                        $error("copies_held: expected %0d, got %0d",
                               want.copies, rsp_ch.copies_held);
                        mismatches++;
                    end
                    if (rsp_ch.present !== want.present)
                    begin
                        $error("present: expected %0d, got %0d",
                               want.present, rsp_ch.present);
                        mismatches++;
                    end
                    if (rsp_ch.entries_held !== want.entries)
                    begin
                        $error("entries_held: expected %0d, got %0d",
                               want.entries, rsp_ch.entries_held);
                        mismatches++;
                    end
                end
            end
        end
    end

    // queue one request for the driver
    task automatic queue_req(op_t op, logic [31:0] val);
        bag_req_t r;
        r.op    = op;
        r.value = val;
        pending_reqs = {pending_reqs, r};
        reqs_queued++;
    endtask

    // wait until every queued request has answered, then let the table settle
    task automatic wait_drained();
        while (results_seen < reqs_queued)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // capacity write on the config channel, only called while the table is idle
    task automatic write_capacity(logic [4:0] cap);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.capacity_in_use <= cap;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        // queue refills happen away from the driver's edge
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [31:0] value_pool[8];
        int unsigned pool_size;
        int unsigned roll;
        logic [31:0] val;
        op_t         op;

        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.operation       = OP_QUERY;
        req_ch.value           = '0;
        rsp_ch.ready           = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.capacity_in_use = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty bag, extreme values, duplicates, remove with swap
        queue_req(OP_QUERY,  32'h0000_0000);
        queue_req(OP_REMOVE, 32'h0000_0000);   // remove from empty bag
        queue_req(OP_ADD,    32'h0000_0000);
        queue_req(OP_ADD,    32'hFFFF_FFFF);
        queue_req(OP_ADD,    32'hFFFF_FFFF);
        queue_req(OP_ADD,    32'hA5A5_A5A5);
        queue_req(OP_QUERY,  32'hFFFF_FFFF);
        queue_req(OP_REMOVE, 32'hFFFF_FFFF);   // last entry moves into the hole
        queue_req(OP_QUERY,  32'hFFFF_FFFF);
        queue_req(OP_REMOVE, 32'h5A5A_5A5A);   // absent value
        queue_req(OP_QUERY,  32'hA5A5_A5A5);
        queue_req(OP_ADD,    32'h5A5A_5A5A);
        wait_drained();

        // capacity lowered below the fill: adds refused, the rest still works
        write_capacity(5'd2);
        queue_req(OP_ADD,    32'h0000_0001);
        queue_req(OP_REMOVE, 32'h0000_0000);
        queue_req(OP_QUERY,  32'h0000_0000);
        queue_req(OP_CLEAR,  32'hA5A5_A5A5);
        queue_req(OP_ADD,    32'h0000_0007);
        queue_req(OP_ADD,    32'h0000_0007);
        queue_req(OP_ADD,    32'h0000_0007);   // bag at capacity
        wait_drained();

        // zero capacity: every add refused
        write_capacity(5'd0);
        queue_req(OP_ADD,    32'h0000_0003);
        queue_req(OP_QUERY,  32'h0000_0003);
        wait_drained();

        // random phases: values mostly from a small pool so that copies pile up
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_capacity(5'(phase_cap[p]));
            send_idle_pct = phase_idle[p];
            rsp_stall_pct = phase_stall[p];
            if (p == pressure_phase)
                hold_arm = 1'b1;

            pool_size = $urandom_range(8, 1);
            for (int k = 0; k < 8; k++)
            begin
                roll = $urandom_range(9);
                value_pool[k] = (roll == 0) ? 32'h0000_0000 :
                                (roll == 1) ? 32'hFFFF_FFFF : $urandom();
            end

            for (int n = 0; n < phase_items[p]; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 42)
                    op = OP_ADD;
                else if (roll < 72)
                    op = OP_REMOVE;
                else if (roll < 96)
                    op = OP_QUERY;
                else
                    op = OP_CLEAR;
                if ($urandom_range(99) < 85)
                    val = value_pool[$urandom_range(pool_size - 1)];
                else
                    val = $urandom();
                queue_req(op, val);
            end
            wait_drained();
        end

        if (awaited_results.size() != 0)
        begin
            $error("%0d results never arrived", awaited_results.size());
            mismatches++;
        end

        $display("%0d requests checked over %0d capacity writes, %0d refused",
                 results_seen, cap_writes, refused_ops);
        $display("deepest fill %0d entries, most copies of one value %0d",
                 peak_fill, peak_copies);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/mbt_pkg.sv
sv/mbt_ifs.sv
sv/mbt_cell.sv
sv/mbt_ctrl.sv
sv/multiset_bag_table.sv
dv/tb_multiset_bag_table.sv
